// ===== rtl/signed_int_to_decimal_ascii_assert.svh =====
// assertion macros for the decimal text converter
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SITDA_ASSERT_IMPL(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("sitda assertion failed");

// next-cycle implication, checked outside reset
`define SITDA_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("sitda assertion failed");

`endif

// ===== rtl/sitda_pkg.sv =====
`timescale 1ns / 1ps

package sitda_pkg;

	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CharWidth  = 7;
	localparam int unsigned MaxDigits  = 10;
	localparam int unsigned DigitIdxW  = $clog2(MaxDigits);

	localparam logic [CharWidth-1:0] AsciiZero  = 7'd48;
	localparam logic [CharWidth-1:0] AsciiMinus = 7'd45;

	// floor(n * Recip10 / 2^Recip10Shift) == n / 10 for every 32-bit n
	localparam logic [ValueWidth-1:0] Recip10      = 32'hCCCC_CCCD;
	localparam int unsigned           Recip10Shift = 35;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUB,
		ST_EMIT
	} sitda_state_t;

endpackage

// ===== rtl/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// channel   signals                        word
// --------  -----------------------------  ---------------------------------
// input     in_valid, in_stall, value      one signed 32-bit integer
// output    out_valid, out_stall,          one ascii character, last marks
//           character, last                the final character of a number
//
// steps: accept, then per decimal digit d (d = 1..10) a multiply on the shared
//   reciprocal multiplier and a subtract, then the characters (sign + d) in turn
// "-2147483648" is the longest word: a sign and ten digits
// in_stall is high from accept until the last character enters the output register
// out_stall holds the output register and pauses character emission
// arst_n clears the sequencer and output valid; no clearing pass
module signed_int_to_decimal_ascii (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic signed [sitda_pkg::ValueWidth-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sitda_pkg::CharWidth-1:0]    character,
	output logic                               last
);
	import sitda_pkg::*;

	`include "signed_int_to_decimal_ascii_assert.svh"

	// sequencer
	sitda_state_t state_q, state_d;

	// datapath registers
	logic [ValueWidth-1:0]   mag_q;          // remaining magnitude
	logic [2*ValueWidth-1:0] prod_q;         // magnitude times reciprocal of ten
	logic [3:0]              digits_q [MaxDigits];  // digits, least significant first
	logic [DigitIdxW-1:0]    ndig_q;         // digits stored so far
	logic [DigitIdxW-1:0]    emit_q;         // next digit to send
	logic                    sign_pend_q;    // minus sign still to send
	logic                    out_valid_q;
	logic [CharWidth-1:0]    char_q;
	logic                    last_q;

	// divide step: quotient from the product, digit by shift-add back-multiply
	logic [ValueWidth-1:0] quot;
	logic [ValueWidth-1:0] quot_x10;
	logic [ValueWidth-1:0] rem_full;
	logic [3:0]            rem;

	assign quot     = (ValueWidth)'(prod_q >> Recip10Shift);
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem_full = mag_q - quot_x10;
	assign rem      = rem_full[3:0];

	logic accept;
	logic load;        // a character enters the output register
	logic out_room;
	logic div_done;

	assign accept   = in_valid && !in_stall;
	assign out_room = !out_valid_q || !out_stall;
	assign div_done = (quot == '0) || (ndig_q == DigitIdxW'(MaxDigits - 1));

	// next state and control
	always_comb begin
		state_d  = state_q;
		load     = 1'b0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_SUB;
			end
			ST_SUB: begin
				state_d = div_done ? ST_EMIT : ST_MUL;
			end
			ST_EMIT: begin
				if (out_room) begin
					load = 1'b1;
					if (!sign_pend_q && emit_q == '0) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			sign_pend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				sign_pend_q <= value[ValueWidth-1];
			end else if (load) begin
				sign_pend_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			// unsigned negation also covers the most negative value (2^31)
			mag_q  <= value[ValueWidth-1] ? (ValueWidth'(0) - ValueWidth'(value))
			                              : ValueWidth'(value);
			ndig_q <= '0;
		end
		if (state_q == ST_MUL) begin
			prod_q <= {{ValueWidth{1'b0}}, mag_q} * {{ValueWidth{1'b0}}, Recip10};
		end
		if (state_q == ST_SUB) begin
			digits_q[ndig_q] <= rem;
			mag_q            <= quot;
			ndig_q           <= ndig_q + 1'b1;
			emit_q           <= ndig_q;
		end
		if (load) begin
			if (sign_pend_q) begin
				char_q <= AsciiMinus;
				last_q <= 1'b0;
			end else begin
				char_q <= AsciiZero + {3'b000, digits_q[emit_q]};
				last_q <= (emit_q == '0);
				if (emit_q != '0) begin
					emit_q <= emit_q - 1'b1;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

	// an accepted word always starts the divide loop
	`SITDA_ASSERT_NEXT(a_accept_to_mul, clk, arst_n, accept, state_q == ST_MUL)
	// only the sign or a digit ever leaves the block
	`SITDA_ASSERT_IMPL(a_char_code, clk, arst_n, out_valid,
		(character == AsciiMinus) || ((character >= AsciiZero) &&
		(character <= AsciiZero + 7'd9)))
	// the sign is never the final character
	`SITDA_ASSERT_IMPL(a_sign_not_last, clk, arst_n,
		out_valid && (character == AsciiMinus), !last)

endmodule
